FILE: rtl/lrgd_pkg.sv
// lrgd_pkg: shared types, codes, defaults and saturating helpers
// for the linear regression trainer; no dependencies
package lrgd_pkg;

  // default sizing
  localparam int DEF_MAX_SAMPLES  = 256;
  localparam int DEF_MAX_FEATURES = 16;
  localparam int DEF_FRAC_BITS    = 16;

  // fixed widths of the fields
  localparam int DATA_W = 32;
  localparam int ITER_W = 16;
  localparam int STEP_W = 16;
  localparam int FCNT_W = 5;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  // register reset values
  localparam logic [ITER_W-1:0] ITER_RST = 16'd100;
  localparam logic [STEP_W-1:0] STEP_RST = 16'd655;
  localparam logic [FCNT_W-1:0] FCNT_RST = 5'd1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ITER = 2'd0;
  localparam logic [IDX_W-1:0] REG_STEP = 2'd1;
  localparam logic [IDX_W-1:0] REG_FCNT = 2'd2;

  // gradient clamp +-(2^47 - 1)
  localparam logic signed [63:0] GRAD_LIM = 64'sh0000_7FFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_FEAT = 2'd0,
    MODE_TGT  = 2'd1,
    MODE_PRED = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_FIT  = 2'd0,
    KIND_PRED = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_DROP  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ZFILL, S_FIT_INIT, S_ITER, S_PISSUE, S_PDRAIN, S_ERR, S_GISSUE,
    S_GDRAIN, S_DIV, S_DIVW, S_UMUL, S_UWR, S_DONE, S_PMUL, S_PACC
  } lrgd_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic    fs_we;
    logic    fs_zero;
    logic    ts_we;
    logic    rd_en;
    logic    ts_re;
    logic    mac_grad;
    logic    acc_clr;
    logic    err_calc;
    logic    grad_clr;
    logic    w_clr;
    logic    div_start;
    logic    upd_bias;
    logic    upd_mul;
    logic    upd_wr;
    logic    pv_load;
    logic    pred_mul;
    logic    pred_add;
    logic    psum_clr;
    logic    out_load;
    logic    out_pred;
    kind_t   out_kind;
    status_t out_status;
  } lrgd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic out_busy;
  } lrgd_sts_t;

  // saturate to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // saturating 64-bit add
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else r = s[63:0];
    return r;
  endfunction

endpackage

FILE: rtl/lrgd_ram.sv
// lrgd_ram: generic single write port ram with registered read
// no dependencies
module lrgd_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read, holds when idle
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lrgd_div.sv
// lrgd_div: restoring divider, signed 64-bit dividend by unsigned count,
// quotient truncated toward zero, one bit per cycle; uses lrgd_pkg
module lrgd_div import lrgd_pkg::*; #(
  parameter int DW = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic [DW-1:0]      divisor,
  output logic               done,
  output logic signed [63:0] quotient
);

  logic          busy_r, done_r, neg_r;
  logic [5:0]    cnt_r;
  logic [DW:0]   rem_r;
  logic [63:0]   quo_r;
  logic [DW:0]   rem_sh;
  logic          fits;

  // one quotient bit a step
  assign rem_sh = {rem_r[DW-1:0], quo_r[63]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // payload: magnitude and sign
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[63];
      quo_r <= dividend[63] ? 64'(-dividend) : dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sh - {1'b0, divisor} : rem_sh;
      quo_r <= {quo_r[62:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

FILE: rtl/lrgd_dp.sv
// lrgd_dp: datapath with sample stores, weights, mac pipeline, gradient
// sums, update path and result register; uses lrgd_pkg, lrgd_ram, lrgd_div
module lrgd_dp import lrgd_pkg::*; #(
  parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES,
  parameter int FRAC_BITS    = DEF_FRAC_BITS,
  localparam int ROW_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int COL_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lrgd_cmd_t                cmd,
  input  logic [ROW_W-1:0]         row_idx,
  input  logic [COL_W-1:0]         col_idx,
  input  logic [CNT_W-1:0]         rows,
  input  logic [STEP_W-1:0]        step,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [1:0]               out_result_kind,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic [1:0]               out_status,
  output lrgd_sts_t                sts
);

  localparam int FS_DEPTH = MAX_SAMPLES << COL_W;
  localparam int FS_AW    = (FS_DEPTH > 1) ? $clog2(FS_DEPTH) : 1;
  localparam int TS_AW    = ROW_W;

  logic [FS_AW-1:0]        fs_addr;
  logic [DATA_W-1:0]       fs_rdata, ts_rdata;
  logic signed [31:0]      w_r [MAX_FEATURES];
  logic signed [31:0]      bias_r, err_r, pv_r, w_rd;
  logic signed [63:0]      grad_r [MAX_FEATURES];
  logic signed [63:0]      grad_b_r, acc_r, psum_r, prod_r, sh;
  logic                    v1_r, v2_r, grad1_r, grad2_r;
  logic [COL_W-1:0]        col1_r, col2_r, w_idx;
  logic signed [31:0]      mul_a, mul_b;
  logic signed [63:0]      prod_c;
  logic signed [31:0]      s1, err_nxt, new_w, pred_val;
  logic signed [63:0]      quo, psum_new, div_in;
  logic signed [47:0]      qc;
  logic signed [64:0]      upd_prod_r, delta;
  logic signed [31:0]      old_w;
  logic                    div_done;
  logic                    out_valid_r;
  logic [1:0]              kind_r, status_r;
  logic signed [31:0]      value_r;

  // sample stores
  assign fs_addr = FS_AW'({row_idx, col_idx});

  lrgd_ram #(.W(DATA_W), .DEPTH(FS_DEPTH), .AW(FS_AW)) u_feat (
    .clk(clk), .we(cmd.fs_we), .waddr(fs_addr),
    .wdata(cmd.fs_zero ? '0 : in_value),
    .re(cmd.rd_en), .raddr(fs_addr), .rdata(fs_rdata)
  );

  lrgd_ram #(.W(DATA_W), .DEPTH(MAX_SAMPLES), .AW(TS_AW)) u_tgt (
    .clk(clk), .we(cmd.ts_we), .waddr(row_idx), .wdata(in_value),
    .re(cmd.ts_re), .raddr(row_idx), .rdata(ts_rdata)
  );

  // shared multiplier operands, weight read port
  assign w_idx  = v1_r ? col1_r : col_idx;
  assign w_rd   = w_r[w_idx];
  assign mul_a  = cmd.pred_mul ? pv_r : $signed(fs_rdata);
  assign mul_b  = (v1_r && grad1_r) ? err_r : w_rd;
  assign prod_c = 64'(mul_a) * 64'(mul_b);
  assign sh     = prod_r >>> FRAC_BITS;

  // mac pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    grad1_r <= cmd.mac_grad;
    col1_r  <= col_idx;
    grad2_r <= grad1_r;
    col2_r  <= col1_r;
    if (v1_r || cmd.pred_mul) prod_r <= prod_c;
    if (cmd.pv_load) pv_r <= in_value;
  end

  // error of one row
  assign s1      = sat32(66'(acc_r + 64'(bias_r)));
  assign err_nxt = sat32(66'(s1) - 66'($signed(ts_rdata)));

  always_ff @(posedge clk) begin
    if (cmd.err_calc) err_r <= err_nxt;
  end

  // row accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) acc_r <= '0;
    else if (cmd.acc_clr) acc_r <= '0;
    else if (v2_r && !grad2_r) acc_r <= acc_r + sh;
  end

  // gradient sums
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.grad_clr) begin
      for (int k = 0; k < MAX_FEATURES; k++) grad_r[k] <= '0;
      grad_b_r <= '0;
    end else begin
      if (v2_r && grad2_r) grad_r[col2_r] <= sat_add64(grad_r[col2_r], sh);
      if (cmd.err_calc) grad_b_r <= sat_add64(grad_b_r, 64'(err_nxt));
    end
  end

  // mean gradient
  assign div_in = cmd.upd_bias ? grad_b_r : grad_r[col_idx];

  lrgd_div #(.DW(CNT_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(div_in),
    .divisor(rows), .done(div_done), .quotient(quo)
  );

  // clamp and scale by step size
  always_comb begin
    if (quo > GRAD_LIM) qc = GRAD_LIM[47:0];
    else if (quo < -GRAD_LIM) qc = 48'(-GRAD_LIM);
    else qc = quo[47:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_mul) upd_prod_r <= 65'($signed({1'b0, step})) * 65'(qc);
  end

  assign delta = upd_prod_r >>> 16;
  assign old_w = cmd.upd_bias ? bias_r : w_rd;
  assign new_w = sat32(66'(old_w) - 66'(delta));

  // weights and bias
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.w_clr) begin
      for (int k = 0; k < MAX_FEATURES; k++) w_r[k] <= '0;
      bias_r <= '0;
    end else if (cmd.upd_wr) begin
      if (cmd.upd_bias) bias_r <= new_w;
      else w_r[col_idx] <= new_w;
    end
  end

  // prediction sum
  assign psum_new = psum_r + (cmd.pred_add ? sh : 64'sd0);
  assign pred_val = sat32(66'(psum_new + 64'(bias_r)));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.psum_clr) psum_r <= '0;
    else psum_r <= psum_new;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind_r   <= cmd.out_kind;
      status_r <= cmd.out_status;
      value_r  <= cmd.out_pred ? pred_val : 32'sd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_result_value = value_r;
  assign out_status       = status_r;
  assign sts.div_done     = div_done;
  assign sts.out_busy     = out_valid_r && !out_ready;

endmodule

FILE: rtl/lrgd_ctrl.sv
// lrgd_ctrl: controller fsm with load counters, fit loop counters and
// prediction sequencing; uses lrgd_pkg
module lrgd_ctrl import lrgd_pkg::*; #(
  parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES,
  localparam int ROW_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int COL_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int FC_W  = $clog2(MAX_FEATURES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic              in_last_sample,
  input  logic [ITER_W-1:0] iter_cfg,
  input  logic [FCNT_W-1:0] fcnt_cfg,
  input  lrgd_sts_t         sts,
  output lrgd_cmd_t         cmd,
  output logic [ROW_W-1:0]  row_idx,
  output logic [COL_W-1:0]  col_idx,
  output logic [CNT_W-1:0]  rows
);

  lrgd_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  sample_cnt_r, sample_cnt_nxt, row_r, row_nxt, rows_r, rows_nxt;
  logic [FC_W-1:0]   col_cnt_r, col_cnt_nxt, j_r, j_nxt, fc, col_inc;
  logic              fitted_r, fitted_nxt, ovf_r, ovf_nxt, last_r, last_nxt;
  logic              drain_r, drain_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [6:0]        fcx;
  logic              acc, full, col_open, j_end, emit;
  mode_t             mode;

  // active feature count, clamped
  assign fcx = {2'b00, fcnt_cfg};
  always_comb begin
    if (fcx == 7'd0) fc = FC_W'(1);
    else if (fcx > 7'(MAX_FEATURES)) fc = FC_W'(MAX_FEATURES);
    else fc = FC_W'(fcx);
  end

  assign mode     = mode_t'(in_mode);
  assign in_ready = (state_r == S_IDLE) && !sts.out_busy;
  assign acc      = in_valid && in_ready;
  assign full     = sample_cnt_r >= CNT_W'(MAX_SAMPLES);
  assign col_open = col_cnt_r < fc;
  assign j_end    = j_r == fc - FC_W'(1);
  assign col_inc  = col_cnt_r + FC_W'(col_open);
  assign emit     = col_inc >= fc;

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sample_cnt_r <= '0;
      col_cnt_r    <= '0;
      fitted_r     <= 1'b0;
      ovf_r        <= 1'b0;
      last_r       <= 1'b0;
      row_r        <= '0;
      rows_r       <= CNT_W'(1);
      j_r          <= '0;
      drain_r      <= 1'b0;
      iter_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      sample_cnt_r <= sample_cnt_nxt;
      col_cnt_r    <= col_cnt_nxt;
      fitted_r     <= fitted_nxt;
      ovf_r        <= ovf_nxt;
      last_r       <= last_nxt;
      row_r        <= row_nxt;
      rows_r       <= rows_nxt;
      j_r          <= j_nxt;
      drain_r      <= drain_nxt;
      iter_r       <= iter_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && mode == MODE_TGT) begin
          if (!full && col_cnt_r < FC_W'(MAX_FEATURES)) state_nxt = S_ZFILL;
          else if (in_last_sample) state_nxt = S_FIT_INIT;
        end else if (acc && mode == MODE_PRED && fitted_r) begin
          state_nxt = S_PMUL;
        end
      end
      S_ZFILL:    if (j_r == FC_W'(MAX_FEATURES - 1))
                    state_nxt = last_r ? S_FIT_INIT : S_IDLE;
      S_FIT_INIT: state_nxt = (iter_cfg == '0) ? S_DONE : S_ITER;
      S_ITER:     state_nxt = S_PISSUE;
      S_PISSUE:   if (j_end) state_nxt = S_PDRAIN;
      S_PDRAIN:   if (drain_r) state_nxt = S_ERR;
      S_ERR:      state_nxt = S_GISSUE;
      S_GISSUE:   if (j_end) state_nxt = S_GDRAIN;
      S_GDRAIN:   if (drain_r)
                    state_nxt = (row_r == rows_r - CNT_W'(1)) ? S_DIV : S_PISSUE;
      S_DIV:      state_nxt = S_DIVW;
      S_DIVW:     if (sts.div_done) state_nxt = S_UMUL;
      S_UMUL:     state_nxt = S_UWR;
      S_UWR: begin
        if (j_r == fc) state_nxt = (iter_r + 16'd1 == iter_cfg) ? S_DONE : S_ITER;
        else state_nxt = S_DIV;
      end
      S_DONE:     if (!sts.out_busy) state_nxt = S_IDLE;
      S_PMUL:     state_nxt = S_PACC;
      S_PACC:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // counters and flags
  always_comb begin
    sample_cnt_nxt = sample_cnt_r;
    col_cnt_nxt    = col_cnt_r;
    fitted_nxt     = fitted_r;
    ovf_nxt        = ovf_r;
    last_nxt       = last_r;
    row_nxt        = row_r;
    rows_nxt       = rows_r;
    j_nxt          = j_r;
    drain_nxt      = drain_r;
    iter_nxt       = iter_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && mode == MODE_FEAT) begin
          if (full) ovf_nxt = 1'b1;
          else if (col_open) col_cnt_nxt = col_cnt_r + FC_W'(1);
        end else if (acc && mode == MODE_TGT) begin
          if (full) ovf_nxt = 1'b1;
          else begin
            row_nxt        = sample_cnt_r;
            j_nxt          = col_cnt_r;
            sample_cnt_nxt = sample_cnt_r + CNT_W'(1);
          end
          col_cnt_nxt = '0;
          last_nxt    = in_last_sample;
        end
      end
      S_ZFILL:    j_nxt = j_r + FC_W'(1);
      S_FIT_INIT: begin
        rows_nxt = (sample_cnt_r == '0) ? CNT_W'(1) : sample_cnt_r;
        iter_nxt = '0;
      end
      S_ITER: begin
        row_nxt = '0;
        j_nxt   = '0;
      end
      S_PISSUE, S_GISSUE: begin
        j_nxt     = j_end ? '0 : j_r + FC_W'(1);
        drain_nxt = 1'b0;
      end
      S_PDRAIN:   drain_nxt = !drain_r;
      S_ERR:      j_nxt = '0;
      S_GDRAIN: begin
        drain_nxt = !drain_r;
        if (drain_r) begin
          j_nxt = '0;
          if (row_r != rows_r - CNT_W'(1)) row_nxt = row_r + CNT_W'(1);
        end
      end
      S_UWR: begin
        if (j_r == fc) begin
          iter_nxt = iter_r + 16'd1;
          j_nxt    = '0;
        end else begin
          j_nxt = j_r + FC_W'(1);
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          fitted_nxt     = 1'b1;
          sample_cnt_nxt = '0;
          ovf_nxt        = 1'b0;
        end
      end
      S_PACC:     col_cnt_nxt = emit ? '0 : col_inc;
      S_DIV, S_DIVW, S_UMUL, S_PMUL: ;
      default: ;
    endcase
  end

  // command outputs
  always_comb begin
    cmd            = '0;
    cmd.out_kind   = KIND_FIT;
    cmd.out_status = ST_OK;
    cmd.upd_bias   = j_r == fc;
    unique case (state_r)
      S_IDLE: begin
        if (acc && mode == MODE_FEAT) cmd.fs_we = !full && col_open;
        if (acc && mode == MODE_TGT) begin
          cmd.ts_we    = !full;
          cmd.psum_clr = 1'b1;
        end
        if (acc && mode == MODE_PRED) begin
          if (fitted_r) begin
            cmd.pv_load = 1'b1;
          end else begin
            cmd.out_load   = 1'b1;
            cmd.out_kind   = KIND_ERR;
            cmd.out_status = ST_NOFIT;
          end
        end
      end
      S_ZFILL: begin
        cmd.fs_we   = 1'b1;
        cmd.fs_zero = 1'b1;
      end
      S_FIT_INIT: cmd.w_clr = 1'b1;
      S_ITER: begin
        cmd.grad_clr = 1'b1;
        cmd.acc_clr  = 1'b1;
      end
      S_PISSUE: begin
        cmd.rd_en = 1'b1;
        cmd.ts_re = j_r == '0;
      end
      S_ERR: begin
        cmd.err_calc = 1'b1;
        cmd.acc_clr  = 1'b1;
      end
      S_GISSUE: begin
        cmd.rd_en    = 1'b1;
        cmd.mac_grad = 1'b1;
      end
      S_DIV:  cmd.div_start = 1'b1;
      S_UMUL: cmd.upd_mul = 1'b1;
      S_UWR:  cmd.upd_wr = 1'b1;
      S_DONE: begin
        cmd.out_load   = !sts.out_busy;
        cmd.out_status = ovf_r ? ST_DROP : ST_OK;
      end
      S_PMUL: cmd.pred_mul = 1'b1;
      S_PACC: begin
        cmd.pred_add = col_open;
        if (emit) begin
          cmd.out_load = 1'b1;
          cmd.out_pred = 1'b1;
          cmd.out_kind = KIND_PRED;
          cmd.psum_clr = 1'b1;
        end
      end
      S_PDRAIN, S_GDRAIN, S_DIVW: ;
      default: ;
    endcase
  end

  // indices toward the datapath
  assign row_idx = (state_r == S_IDLE) ? sample_cnt_r[ROW_W-1:0] : row_r[ROW_W-1:0];
  assign col_idx = (state_r == S_IDLE || state_r == S_PMUL) ? col_cnt_r[COL_W-1:0]
                                                            : j_r[COL_W-1:0];
  assign rows    = rows_r;

  // checks
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_cnt_r <= FC_W'(MAX_FEATURES))
    else $error("column counter beyond feature capacity");

  a_smp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sample_cnt_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample counter beyond capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded while previous one still pending");

  a_fit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !sts.out_busy) |=> (sample_cnt_r == '0 && !ovf_r && fitted_r))
    else $error("load state not cleared after fit");

endmodule

FILE: rtl/linear_regression_gd_trainer_unit.sv
// linear_regression_gd_trainer_unit: top level with register file,
// controller and datapath; uses lrgd_pkg, lrgd_ctrl, lrgd_dp
// load: one training value per cycle while in_ready is high; after a target, the columns
//   left unwritten in its row are filled with zeros, up to MAX_FEATURES
// prediction: each value goes through the shared 32x32 multiplier; the next is taken after it is summed
// fit: each iteration runs the rows through the single mac pipeline, then updates each
//   weight and the bias through the 64-step divider
// reset: synchronous active low; sample stores are not cleared
module linear_regression_gd_trainer_unit import lrgd_pkg::*; #(
  parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_mode,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_result_kind,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic [1:0]               out_status
);

  localparam int ROW_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int COL_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  logic [ITER_W-1:0] iter_r;
  logic [STEP_W-1:0] step_r;
  logic [FCNT_W-1:0] fcnt_r;
  lrgd_cmd_t         cmd;
  lrgd_sts_t         sts;
  logic [ROW_W-1:0]  row_idx;
  logic [COL_W-1:0]  col_idx;
  logic [CNT_W-1:0]  rows;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= ITER_RST;
      step_r <= STEP_RST;
      fcnt_r <= FCNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ITER: iter_r <= cfg_wdata[ITER_W-1:0];
        REG_STEP: step_r <= cfg_wdata[STEP_W-1:0];
        REG_FCNT: fcnt_r <= cfg_wdata[FCNT_W-1:0];
        default: ;
      endcase
    end
  end

  lrgd_ctrl #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_FEATURES(MAX_FEATURES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_last_sample(in_last_sample), .iter_cfg(iter_r),
    .fcnt_cfg(fcnt_r), .sts(sts), .cmd(cmd), .row_idx(row_idx),
    .col_idx(col_idx), .rows(rows)
  );

  lrgd_dp #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_FEATURES(MAX_FEATURES),
            .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .row_idx(row_idx), .col_idx(col_idx),
    .rows(rows), .step(step_r), .in_value(in_value), .out_ready(out_ready),
    .out_valid(out_valid), .out_result_kind(out_result_kind),
    .out_result_value(out_result_value), .out_status(out_status), .sts(sts)
  );

endmodule

FILE: tb/sv/linear_regression_gd_trainer_unit_tb.sv
// linear_regression_gd_trainer_unit_tb: self-checking bench for the gradient descent trainer
// holds a bit-exact fit/predict model in a scoreboard class; depends on lrgd_pkg and the rtl
module linear_regression_gd_trainer_unit_tb;
  import lrgd_pkg::*;

  localparam int NUM_ROWS  = 256;
  localparam int NUM_COLS  = 16;
  localparam int FRAC      = 16;
  localparam int SETTLE    = 200;
  localparam int LONG_HOLD = 300;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    kind_t              kind;
    logic signed [31:0] value;
    status_t            status;
  } result_t;

  // fit and prediction model with its queue of pending results
  class gd_fit_scoreboard;
    longint      feat_mem[NUM_ROWS*NUM_COLS];
    longint      tgt_mem[NUM_ROWS];
    longint      err_mem[NUM_ROWS];
    longint      weights[NUM_COLS];
    longint      bias;
    longint      grad[NUM_COLS+1];
    int unsigned row_cnt, col_cnt;
    longint      dot_acc;
    bit          fitted, dropped;
    int unsigned iters, step, fcount;
    result_t     pending_results[$];
    int          errors;

    function new();
      iters = ITER_RST; step = STEP_RST; fcount = FCNT_RST;
      foreach (weights[i]) weights[i] = 0;
      bias = 0; row_cnt = 0; col_cnt = 0; dot_acc = 0;
      fitted = 0; dropped = 0; errors = 0;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function int unsigned used_cols();
      if (fcount < 1) return 1;
      if (fcount > NUM_COLS) return NUM_COLS;
      return fcount;
    endfunction

    function longint fmul(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> FRAC;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (a > 0 && b > 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
      return s;
    endfunction

    function longint step_weight(longint old, longint g);
      longint d;
      if (g > GRAD_LIM) g = GRAD_LIM;
      if (g < -GRAD_LIM) g = -GRAD_LIM;
      d = (longint'(step) * g) >>> 16;
      return sat32(old - d);
    endfunction

    function void run_fit(int unsigned rows);
      int unsigned fc;
      longint acc, e;
      fc = used_cols();
      foreach (weights[i]) weights[i] = 0;
      bias = 0;
      for (int unsigned it = 0; it < iters; it++) begin
        for (int unsigned i = 0; i < rows; i++) begin
          acc = 0;
          for (int unsigned j = 0; j < fc; j++)
            acc += fmul(feat_mem[i*NUM_COLS+j], weights[j]);
          err_mem[i] = sat32(sat32(acc + bias) - tgt_mem[i]);
        end
        foreach (grad[j]) grad[j] = 0;
        for (int unsigned i = 0; i < rows; i++) begin
          e = err_mem[i];
          for (int unsigned j = 0; j < fc; j++)
            grad[j] = sat_add(grad[j], fmul(feat_mem[i*NUM_COLS+j], e));
          grad[NUM_COLS] = sat_add(grad[NUM_COLS], e);
        end
        for (int unsigned j = 0; j < fc; j++)
          weights[j] = step_weight(weights[j], grad[j] / longint'(rows));
        bias = step_weight(bias, grad[NUM_COLS] / longint'(rows));
      end
      fitted = 1;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ITER: iters = data;
        REG_STEP: step = data;
        REG_FCNT: fcount = data[FCNT_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted input beat
    function void note_input(logic [1:0] mode, logic signed [31:0] v, logic last);
      longint val;
      int unsigned fc;
      result_t r;
      val = v;
      fc = used_cols();
      case (mode)
        MODE_FEAT: begin
          if (row_cnt >= NUM_ROWS) dropped = 1;
          else if (col_cnt < fc) begin
            feat_mem[row_cnt*NUM_COLS+col_cnt] = val;
            col_cnt++;
          end
        end
        MODE_TGT: begin
          if (row_cnt >= NUM_ROWS) dropped = 1;
          else begin
            for (int unsigned c = col_cnt; c < NUM_COLS; c++) feat_mem[row_cnt*NUM_COLS+c] = 0;
            tgt_mem[row_cnt] = val;
            row_cnt++;
          end
          col_cnt = 0;
          dot_acc = 0;
          if (last) begin
            run_fit(row_cnt == 0 ? 1 : row_cnt);
            r.kind = KIND_FIT; r.value = 0; r.status = dropped ? ST_DROP : ST_OK;
            pending_results.push_back(r);
            row_cnt = 0;
            dropped = 0;
          end
        end
        MODE_PRED: begin
          if (!fitted) begin
            r.kind = KIND_ERR; r.value = 0; r.status = ST_NOFIT;
            pending_results.push_back(r);
          end else begin
            if (col_cnt < fc) begin
              dot_acc += fmul(val, weights[col_cnt]);
              col_cnt++;
            end
            if (col_cnt >= fc) begin
              r.kind = KIND_PRED; r.value = sat32(dot_acc + bias); r.status = ST_OK;
              pending_results.push_back(r);
              dot_acc = 0;
              col_cnt = 0;
            end
          end
        end
        default: ;
      endcase
    endfunction

    // one accepted result beat
    task check_result(logic [1:0] kind, logic signed [31:0] value, logic [1:0] status);
      result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d value %0d", kind, value));
        return;
      end
      e = pending_results.pop_front();
      if (kind !== e.kind) report($sformatf("kind %0d, want %0d", kind, e.kind));
      if (value !== e.value) report($sformatf("value %0d, want %0d", value, e.value));
      if (status !== e.status) report($sformatf("status %0d, want %0d", status, e.status));
    endtask
  endclass

  logic                     clk = 0;
  logic                     rst_n = 0;
  logic                     cfg_we = 0;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]         cfg_wdata = '0;
  logic                     in_valid = 0;
  logic                     in_ready;
  logic [1:0]               in_mode = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     in_last_sample = 0;
  logic                     out_valid;
  logic                     out_ready = 0;
  logic [1:0]               out_result_kind;
  logic signed [DATA_W-1:0] out_result_value;
  logic [1:0]               out_status;

  gd_fit_scoreboard sb = new();
  bit          quiet = 0;
  bit          hold_req = 0;
  int unsigned act_fc = 1;

  linear_regression_gd_trainer_unit dut (.*);

  initial forever #1 clk = ~clk;

  // result side: random back-pressure plus one long hold on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else
        out_ready = 1;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_result_kind, out_result_value, out_status);

  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

  // drive one beat, called and returning at a falling edge
  task send_beat(mode_t mode, logic signed [31:0] v, logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1;
    in_mode = mode;
    in_value = v;
    in_last_sample = last;
    do @(posedge clk); while (!in_ready);
    sb.note_input(in_mode, in_value, in_last_sample);
    @(negedge clk);
  endtask

  // drain everything and let the block go idle
  task settle();
    in_valid = 0;
    while (sb.pending_results.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 0;
    sb.write_reg(idx, data);
    act_fc = sb.used_cols();
  endtask

  function logic signed [31:0] rand_value();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
  endfunction

  // rows with random content and feature counts, predictions and mode 3 noise mixed in
  task random_phase(int n_items, bit with_fits);
    int sent, rows, goal, k;
    sent = 0; rows = 0; goal = $urandom_range(1, 5);
    while (sent < n_items) begin
      k = $urandom_range(0, 99);
      if (with_fits && k < 45) begin
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, act_fc + 2) : act_fc;
        repeat (k) send_beat(MODE_FEAT, rand_value(), $urandom_range(0, 1));
        rows++;
        send_beat(MODE_TGT, rand_value(), rows >= goal);
        if (rows >= goal) begin
          rows = 0;
          goal = $urandom_range(1, 5);
        end
        sent += k + 1;
      end else if (k < 92) begin
        repeat (act_fc) send_beat(MODE_PRED, rand_value(), $urandom_range(0, 1));
        sent += act_fc;
      end else
        send_beat(MODE_NONE, $urandom, $urandom_range(0, 1));
    end
    if (with_fits && rows > 0) send_beat(MODE_TGT, rand_value(), 1);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // prediction before any fit, unused mode
    send_beat(MODE_PRED, 32'sh7FFF_FFFF, 0);
    send_beat(MODE_PRED, 32'sh8000_0000, 1);
    send_beat(MODE_NONE, 32'sh1234_5678, 1);
    settle();
    write_reg(REG_FCNT, 16'd2);
    write_reg(REG_ITER, 16'd3);
    write_reg(REG_STEP, 16'd65535);

    // extreme values, extra feature, short row, then fit
    send_beat(MODE_FEAT, 32'sh7FFF_FFFF, 0);
    send_beat(MODE_FEAT, 32'sh8000_0000, 1);
    send_beat(MODE_FEAT, 32'sh0001_2345, 0);
    send_beat(MODE_TGT, -32'sd1, 0);
    send_beat(MODE_FEAT, 32'sd0, 0);
    send_beat(MODE_TGT, 32'sh7FFF_FFFF, 0);
    send_beat(MODE_FEAT, 32'sh8000_0000, 0);
    send_beat(MODE_FEAT, 32'sh7FFF_FFFF, 0);
    send_beat(MODE_TGT, 32'sh8000_0000, 1);
    send_beat(MODE_PRED, 32'sh0001_0000, 0);
    send_beat(MODE_PRED, -32'sh0002_0000, 0);

    // prediction and training sharing one column counter
    send_beat(MODE_PRED, 32'sh0003_0000, 0);
    send_beat(MODE_FEAT, 32'sh0000_8000, 0);
    send_beat(MODE_TGT, 32'sh0005_0000, 1);
    send_beat(MODE_PRED, 32'sh0001_0000, 0);
    send_beat(MODE_PRED, 32'sh0001_0000, 0);
    settle();

    // fill to capacity and beyond, clamped feature count
    write_reg(REG_FCNT, 16'd0);
    write_reg(REG_ITER, 16'd1);
    write_reg(REG_STEP, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    for (int i = 0; i < NUM_ROWS + 2; i++) begin
      send_beat(MODE_FEAT, rand_value(), 0);
      send_beat(MODE_TGT, rand_value(), i == NUM_ROWS + 1);
    end
    settle();

    // long output hold while predictions keep coming
    write_reg(REG_STEP, 16'd655);
    send_beat(MODE_TGT, 32'sh0002_0000, 1);
    hold_req = 1;
    repeat (40) send_beat(MODE_PRED, rand_value(), 0);
    settle();

    write_reg(REG_ITER, 16'd65535);
    random_phase(60, 0);
    settle();
    write_reg(REG_ITER, 16'd2);
    write_reg(REG_FCNT, 16'd3);
    random_phase(120, 1);
    settle();
    write_reg(REG_ITER, 16'd1);
    write_reg(REG_STEP, 16'd65535);
    write_reg(REG_FCNT, 16'd16);
    random_phase(120, 1);
    settle();
    write_reg(REG_ITER, 16'd0);
    write_reg(REG_STEP, 16'd100);
    write_reg(REG_FCNT, 16'd4);
    random_phase(60, 1);
    settle();
    write_reg(REG_ITER, 16'd3);
    write_reg(REG_STEP, 16'd32768);
    write_reg(REG_FCNT, 16'd31);
    random_phase(100, 1);
    settle();
    write_reg(REG_ITER, 16'd2);
    write_reg(REG_STEP, 16'd20000);
    write_reg(REG_FCNT, 16'd1);
    random_phase(80, 1);
    quiet = 1;
    random_phase(60, 1);
    in_valid = 0;

    while (sb.pending_results.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
